[hdl/rgb_cop_pkg.sv]
package rgb_cop_pkg;

  localparam int ChW = 5;
  localparam int ByteW = 8;
  localparam int OpW = 3;
  localparam int SecW = 3;

  localparam logic [OpW-1:0] OP_BLEND  = 3'd0;
  localparam logic [OpW-1:0] OP_DARKEN = 3'd1;
  localparam logic [OpW-1:0] OP_LIGHT  = 3'd2;
  localparam logic [OpW-1:0] OP_BRIGHT = 3'd3;
  localparam logic [OpW-1:0] OP_INVERT = 3'd4;
  localparam logic [OpW-1:0] OP_GRAY   = 3'd5;
  localparam logic [OpW-1:0] OP_HSV    = 3'd6;

  localparam logic [ChW-1:0] ChMax = 5'd31;
  localparam logic [ByteW-1:0] ByteMax = 8'd255;
  localparam logic [ByteW-1:0] SectorSpan = 8'd43;

  // blend and gray sums fit 13 bits (max 31*255 + 128, 31*256)
  localparam int SumW = 13;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ChW-1:0]   r1;
    logic [ChW-1:0]   g1;
    logic [ChW-1:0]   b1;
    logic [ChW-1:0]   r2;
    logic [ChW-1:0]   g2;
    logic [ChW-1:0]   b2;
    logic [ByteW-1:0] f;
    logic [ByteW-1:0] nf;
    logic             adj_sub;
    logic [ChW-1:0]   amt;
    logic [SecW-1:0]  sector;
    logic [ByteW-1:0] rem;
    logic [ByteW-1:0] s;
    logic [ByteW-1:0] ns;
    logic [ByteW-1:0] v;
    logic             sat_zero;
  } s1_t;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ChW-1:0]   r1;
    logic [ChW-1:0]   g1;
    logic [ChW-1:0]   b1;
    logic             adj_sub;
    logic [ChW-1:0]   amt;
    logic [SumW-1:0]  blend_r;
    logic [SumW-1:0]  blend_g;
    logic [SumW-1:0]  blend_b;
    logic [SumW-1:0]  gray;
    logic [ByteW-1:0] srem;
    logic [ByteW-1:0] strem;
    logic [ByteW-1:0] p;
    logic [ByteW-1:0] v;
    logic [SecW-1:0]  sector;
    logic             sat_zero;
  } s2_t;

  typedef struct packed {
    logic [ChW-1:0] r;
    logic [ChW-1:0] g;
    logic [ChW-1:0] b;
  } rgb_t;

  function automatic logic [SecW-1:0] hue_sector(input logic [ByteW-1:0] h);
    logic [SecW-1:0] sec;
    if (h >= 8'd215) begin
      sec = 3'd5;
    end else if (h >= 8'd172) begin
      sec = 3'd4;
    end else if (h >= 8'd129) begin
      sec = 3'd3;
    end else if (h >= 8'd86) begin
      sec = 3'd2;
    end else if (h >= SectorSpan) begin
      sec = 3'd1;
    end else begin
      sec = 3'd0;
    end
    return sec;
  endfunction

  function automatic logic [ByteW-1:0] sector_base(input logic [SecW-1:0] sec);
    logic [ByteW-1:0] base;
    case (sec)
      3'd1:    base = 8'd43;
      3'd2:    base = 8'd86;
      3'd3:    base = 8'd129;
      3'd4:    base = 8'd172;
      3'd5:    base = 8'd215;
      default: base = 8'd0;
    endcase
    return base;
  endfunction

endpackage

[hdl/rgb555_color_op_unit_core.sv]
// rgb555 color operation unit: blend, darken, lighten, signed brightness,
// invert, grayscale and hsv to rgb on unpacked 5-bit red, green, blue
// input channel: in_valid_i / in_stall_o, one item per accepted edge
// carrying the opcode, two colors, factor and hsv bytes
// output channel: out_valid_o / out_stall_i, one color per item, in order
// three register stages: decode (hue sector, amounts), products
// (blend, gray, hsv partial products), second hsv products and final select
// an accepted item passes the three stages in order before out_valid_o rises
// throughput is one item per cycle unless out_stall_i holds the pipe;
// the hsv chain of two dependent 8x8 multiplies sets the stage split
// reset clears the stage valid bits only; the pipe is empty afterwards
// a stall on the output holds the last stage; earlier stages keep filling
// any empty slot, so in_stall_o rises only once all three stages hold items
// items are never dropped or repeated under stall
module rgb555_color_op_unit_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rgb_cop_pkg::OpW-1:0]   operation_i,
  input  logic [rgb_cop_pkg::ChW-1:0]   first_red_i,
  input  logic [rgb_cop_pkg::ChW-1:0]   first_green_i,
  input  logic [rgb_cop_pkg::ChW-1:0]   first_blue_i,
  input  logic [rgb_cop_pkg::ChW-1:0]   second_red_i,
  input  logic [rgb_cop_pkg::ChW-1:0]   second_green_i,
  input  logic [rgb_cop_pkg::ChW-1:0]   second_blue_i,
  input  logic [rgb_cop_pkg::ByteW-1:0] factor_i,
  input  logic [rgb_cop_pkg::ByteW-1:0] hue_i,
  input  logic [rgb_cop_pkg::ByteW-1:0] saturation_i,
  input  logic [rgb_cop_pkg::ByteW-1:0] hsv_level_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rgb_cop_pkg::ChW-1:0]   out_red_o,
  output logic [rgb_cop_pkg::ChW-1:0]   out_green_o,
  output logic [rgb_cop_pkg::ChW-1:0]   out_blue_o
);
  import rgb_cop_pkg::*;

  // stage valid bits
  logic v1_q, v2_q, v3_q;
  logic v1_d, v2_d, v3_d;
  // a stage may load when it is empty or its content moves on
  logic ready1, ready2, ready3;

  s1_t  s1;
  s2_t  s2;
  rgb_t res;

  assign ready3 = !v3_q || !out_stall_i;
  assign ready2 = !v2_q || ready3;
  assign ready1 = !v1_q || ready2;

  assign v1_d = ready1 ? in_valid_i : v1_q;
  assign v2_d = ready2 ? v1_q : v2_q;
  assign v3_d = ready3 ? v2_q : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  // stage 1: operand decode, hue sector and remainder
  rgb_cop_decode u_decode (
    .clk_i          (clk_i),
    .en_i           (ready1),
    .operation_i    (operation_i),
    .first_red_i    (first_red_i),
    .first_green_i  (first_green_i),
    .first_blue_i   (first_blue_i),
    .second_red_i   (second_red_i),
    .second_green_i (second_green_i),
    .second_blue_i  (second_blue_i),
    .factor_i       (factor_i),
    .hue_i          (hue_i),
    .saturation_i   (saturation_i),
    .hsv_level_i    (hsv_level_i),
    .s1_o           (s1)
  );

  // stage 2: blend, gray and first hsv products
  rgb_cop_mult u_mult (
    .clk_i (clk_i),
    .en_i  (ready2),
    .s1_i  (s1),
    .s2_o  (s2)
  );

  // stage 3: q and t products, clamped adjust, result select
  rgb_cop_final u_final (
    .clk_i (clk_i),
    .en_i  (ready3),
    .s2_i  (s2),
    .res_o (res)
  );

  assign in_stall_o  = !ready1;
  assign out_valid_o = v3_q;
  assign out_red_o   = res.r;
  assign out_green_o = res.g;
  assign out_blue_o  = res.b;

endmodule

[hdl/rgb_cop_decode.sv]
module rgb_cop_decode (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [rgb_cop_pkg::OpW-1:0]          operation_i,
  input  logic [rgb_cop_pkg::ChW-1:0]          first_red_i,
  input  logic [rgb_cop_pkg::ChW-1:0]          first_green_i,
  input  logic [rgb_cop_pkg::ChW-1:0]          first_blue_i,
  input  logic [rgb_cop_pkg::ChW-1:0]          second_red_i,
  input  logic [rgb_cop_pkg::ChW-1:0]          second_green_i,
  input  logic [rgb_cop_pkg::ChW-1:0]          second_blue_i,
  input  logic [rgb_cop_pkg::ByteW-1:0]        factor_i,
  input  logic [rgb_cop_pkg::ByteW-1:0]        hue_i,
  input  logic [rgb_cop_pkg::ByteW-1:0]        saturation_i,
  input  logic [rgb_cop_pkg::ByteW-1:0]        hsv_level_i,
  output rgb_cop_pkg::s1_t                     s1_o
);
  import rgb_cop_pkg::*;

  s1_t s1_d, s1_q;
  logic [ByteW-1:0] mag;
  logic [ByteW-1:0] diff;
  logic [ChW-1:0]   f_amt;
  logic [ChW-1:0]   mag_amt;
  logic             neg;

  always_comb begin
    neg     = factor_i[ByteW-1];
    mag     = ~factor_i + 8'd1;
    f_amt   = (factor_i > {3'd0, ChMax}) ? ChMax : factor_i[ChW-1:0];
    mag_amt = (mag > {3'd0, ChMax}) ? ChMax : mag[ChW-1:0];

    s1_d.op     = operation_i;
    s1_d.r1     = first_red_i;
    s1_d.g1     = first_green_i;
    s1_d.b1     = first_blue_i;
    s1_d.r2     = second_red_i;
    s1_d.g2     = second_green_i;
    s1_d.b2     = second_blue_i;
    s1_d.f      = factor_i;
    s1_d.nf     = ByteMax - factor_i;

    // signed brightness darkens by the magnitude of a negative factor
    s1_d.adj_sub = (operation_i == OP_DARKEN) || ((operation_i == OP_BRIGHT) && neg);
    s1_d.amt     = ((operation_i == OP_BRIGHT) && neg) ? mag_amt : f_amt;

    s1_d.sector   = hue_sector(hue_i);
    diff          = hue_i - sector_base(s1_d.sector);
    s1_d.rem      = (diff << 2) + (diff << 1);
    s1_d.s        = saturation_i;
    s1_d.ns       = ByteMax - saturation_i;
    s1_d.v        = hsv_level_i;
    s1_d.sat_zero = (saturation_i == 8'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

[hdl/rgb_cop_mult.sv]
module rgb_cop_mult (
  input  logic             clk_i,
  input  logic             en_i,
  input  rgb_cop_pkg::s1_t s1_i,
  output rgb_cop_pkg::s2_t s2_o
);
  import rgb_cop_pkg::*;

  s2_t s2_d, s2_q;
  logic [2*ByteW-1:0] srem_full;
  logic [2*ByteW-1:0] strem_full;
  logic [2*ByteW-1:0] p_full;

  function automatic logic [SumW-1:0] blend_sum(input logic [ChW-1:0] a,
                                                input logic [ChW-1:0] b,
                                                input logic [ByteW-1:0] wa,
                                                input logic [ByteW-1:0] wb);
    logic [SumW-1:0] pa, pb;
    pa = SumW'(a) * SumW'(wa);
    pb = SumW'(b) * SumW'(wb);
    return pa + pb + SumW'(128);
  endfunction

  always_comb begin
    s2_d.op      = s1_i.op;
    s2_d.r1      = s1_i.r1;
    s2_d.g1      = s1_i.g1;
    s2_d.b1      = s1_i.b1;
    s2_d.adj_sub = s1_i.adj_sub;
    s2_d.amt     = s1_i.amt;

    // ratio 0 and 255 fall out of the rounded formula exactly
    s2_d.blend_r = blend_sum(s1_i.r1, s1_i.r2, s1_i.nf, s1_i.f);
    s2_d.blend_g = blend_sum(s1_i.g1, s1_i.g2, s1_i.nf, s1_i.f);
    s2_d.blend_b = blend_sum(s1_i.b1, s1_i.b2, s1_i.nf, s1_i.f);

    s2_d.gray = SumW'(s1_i.r1) * SumW'(77) + SumW'(s1_i.g1) * SumW'(150)
              + SumW'(s1_i.b1) * SumW'(29);

    srem_full  = s1_i.s * s1_i.rem;
    strem_full = s1_i.s * (ByteMax - s1_i.rem);
    p_full     = s1_i.v * s1_i.ns;
    s2_d.srem  = srem_full[2*ByteW-1:ByteW];
    s2_d.strem = strem_full[2*ByteW-1:ByteW];
    s2_d.p     = p_full[2*ByteW-1:ByteW];

    s2_d.v        = s1_i.v;
    s2_d.sector   = s1_i.sector;
    s2_d.sat_zero = s1_i.sat_zero;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;

endmodule

[hdl/rgb_cop_final.sv]
module rgb_cop_final (
  input  logic              clk_i,
  input  logic              en_i,
  input  rgb_cop_pkg::s2_t  s2_i,
  output rgb_cop_pkg::rgb_t res_o
);
  import rgb_cop_pkg::*;

  rgb_t res_d, res_q;
  logic [2*ByteW-1:0] q_full;
  logic [2*ByteW-1:0] t_full;
  logic [ChW-1:0]     q5, t5, p5, v5, lum;
  rgb_t               hsv, adj;

  function automatic logic [ChW-1:0] adjust_ch(input logic [ChW-1:0] c,
                                               input logic [ChW-1:0] amt,
                                               input logic           sub);
    logic [ChW:0]   sum;
    logic [ChW-1:0] res;
    sum = {1'b0, c} + {1'b0, amt};
    if (sub) begin
      res = (c > amt) ? (c - amt) : '0;
    end else begin
      res = sum[ChW] ? ChMax : sum[ChW-1:0];
    end
    return res;
  endfunction

  always_comb begin
    q_full = s2_i.v * (ByteMax - s2_i.srem);
    t_full = s2_i.v * (ByteMax - s2_i.strem);
    q5 = q_full[2*ByteW-1:ByteW+3];
    t5 = t_full[2*ByteW-1:ByteW+3];
    p5 = s2_i.p[ByteW-1:3];
    v5 = s2_i.v[ByteW-1:3];

    if (s2_i.sat_zero) begin
      hsv = '{r: v5, g: v5, b: v5};
    end else begin
      case (s2_i.sector)
        3'd0:    hsv = '{r: v5, g: t5, b: p5};
        3'd1:    hsv = '{r: q5, g: v5, b: p5};
        3'd2:    hsv = '{r: p5, g: v5, b: t5};
        3'd3:    hsv = '{r: p5, g: q5, b: v5};
        3'd4:    hsv = '{r: t5, g: p5, b: v5};
        default: hsv = '{r: v5, g: p5, b: q5};
      endcase
    end

    adj.r = adjust_ch(s2_i.r1, s2_i.amt, s2_i.adj_sub);
    adj.g = adjust_ch(s2_i.g1, s2_i.amt, s2_i.adj_sub);
    adj.b = adjust_ch(s2_i.b1, s2_i.amt, s2_i.adj_sub);

    lum = (s2_i.gray[SumW-1:8] > {3'd0, ChMax}) ? ChMax : s2_i.gray[ChW+7:8];

    case (s2_i.op)
      OP_BLEND: begin
        res_d.r = s2_i.blend_r[ChW+7:8];
        res_d.g = s2_i.blend_g[ChW+7:8];
        res_d.b = s2_i.blend_b[ChW+7:8];
      end
      OP_DARKEN, OP_LIGHT, OP_BRIGHT: res_d = adj;
      OP_INVERT: begin
        res_d.r = ChMax - s2_i.r1;
        res_d.g = ChMax - s2_i.g1;
        res_d.b = ChMax - s2_i.b1;
      end
      OP_GRAY: res_d = '{r: lum, g: lum, b: lum};
      OP_HSV:  res_d = hsv;
      default: res_d = '{r: s2_i.r1, g: s2_i.g1, b: s2_i.b1};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[bench/tb_rgb555_color_op_unit_core.sv]
module tb_rgb555_color_op_unit_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rgb_cop_pkg::*;

  // opcode 7 has no name in the package, the first color passes through
  localparam logic [OpW-1:0] OpPassThru = 3'd7;
  localparam int unsigned HangLimit = 5000;
  localparam int unsigned DrainCycles = 10;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ChW-1:0]   r1;
    logic [ChW-1:0]   g1;
    logic [ChW-1:0]   b1;
    logic [ChW-1:0]   r2;
    logic [ChW-1:0]   g2;
    logic [ChW-1:0]   b2;
    logic [ByteW-1:0] factor;
    logic [ByteW-1:0] hue;
    logic [ByteW-1:0] sat;
    logic [ByteW-1:0] level;
  } color_req_t;

  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
  } color_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [OpW-1:0] operation_i = '0;
  logic [ChW-1:0] first_red_i = '0;
  logic [ChW-1:0] first_green_i = '0;
  logic [ChW-1:0] first_blue_i = '0;
  logic [ChW-1:0] second_red_i = '0;
  logic [ChW-1:0] second_green_i = '0;
  logic [ChW-1:0] second_blue_i = '0;
  logic [ByteW-1:0] factor_i = '0;
  logic [ByteW-1:0] hue_i = '0;
  logic [ByteW-1:0] saturation_i = '0;
  logic [ByteW-1:0] hsv_level_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [ChW-1:0] out_red_o;
  logic [ChW-1:0] out_green_o;
  logic [ChW-1:0] out_blue_o;

  color_res_t expected_colors[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  rgb555_color_op_unit_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .first_red_i    (first_red_i),
    .first_green_i  (first_green_i),
    .first_blue_i   (first_blue_i),
    .second_red_i   (second_red_i),
    .second_green_i (second_green_i),
    .second_blue_i  (second_blue_i),
    .factor_i       (factor_i),
    .hue_i          (hue_i),
    .saturation_i   (saturation_i),
    .hsv_level_i    (hsv_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_red_o      (out_red_o),
    .out_green_o    (out_green_o),
    .out_blue_o     (out_blue_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // color prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned add_sat(input int unsigned c, input int unsigned amt);
    return (c + amt > 31) ? 31 : c + amt;
  endfunction

  function automatic int unsigned sub_floor(input int unsigned c, input int unsigned amt);
    return (c > amt) ? c - amt : 0;
  endfunction

  function automatic int unsigned mix_chan(input int unsigned a, input int unsigned b,
                                           input int unsigned ratio);
    return (a * (255 - ratio) + b * ratio + 128) >> 8;
  endfunction

  function automatic color_res_t predict_color(input color_req_t req);
    color_res_t res;
    int unsigned f, amt, mag, lum, sector, rem, p, q, t, vv, h, s, v;
    f = req.factor;
    h = req.hue;
    s = req.sat;
    v = req.level;
    amt = (f > 31) ? 31 : f;
    res.red = req.r1;
    res.green = req.g1;
    res.blue = req.b1;
    case (req.op)
      OP_BLEND: begin
        if (f == 255) begin
          res.red = req.r2;
          res.green = req.g2;
          res.blue = req.b2;
        end else if (f != 0) begin
          res.red = ChW'(mix_chan(req.r1, req.r2, f));
          res.green = ChW'(mix_chan(req.g1, req.g2, f));
          res.blue = ChW'(mix_chan(req.b1, req.b2, f));
        end
      end
      OP_DARKEN: begin
        res.red = ChW'(sub_floor(req.r1, amt));
        res.green = ChW'(sub_floor(req.g1, amt));
        res.blue = ChW'(sub_floor(req.b1, amt));
      end
      OP_LIGHT: begin
        res.red = ChW'(add_sat(req.r1, amt));
        res.green = ChW'(add_sat(req.g1, amt));
        res.blue = ChW'(add_sat(req.b1, amt));
      end
      OP_BRIGHT: begin
        // factor as a signed byte: negative darkens by its magnitude
        if (f < 128) begin
          res.red = ChW'(add_sat(req.r1, amt));
          res.green = ChW'(add_sat(req.g1, amt));
          res.blue = ChW'(add_sat(req.b1, amt));
        end else begin
          mag = 256 - f;
          mag = (mag > 31) ? 31 : mag;
          res.red = ChW'(sub_floor(req.r1, mag));
          res.green = ChW'(sub_floor(req.g1, mag));
          res.blue = ChW'(sub_floor(req.b1, mag));
        end
      end
      OP_INVERT: begin
        res.red = ChMax - req.r1;
        res.green = ChMax - req.g1;
        res.blue = ChMax - req.b1;
      end
      OP_GRAY: begin
        lum = (77 * req.r1 + 150 * req.g1 + 29 * req.b1) >> 8;
        lum = (lum > 31) ? 31 : lum;
        res = '{ChW'(lum), ChW'(lum), ChW'(lum)};
      end
      OP_HSV: begin
        vv = v >> 3;
        if (s == 0) begin
          res = '{ChW'(vv), ChW'(vv), ChW'(vv)};
        end else begin
          sector = h / 43;
          rem = (h - sector * 43) * 6;
          p = ((v * (255 - s)) >> 8) >> 3;
          q = ((v * (255 - ((s * rem) >> 8))) >> 8) >> 3;
          t = ((v * (255 - ((s * (255 - rem)) >> 8))) >> 8) >> 3;
          case (sector)
            0: res = '{ChW'(vv), ChW'(t), ChW'(p)};
            1: res = '{ChW'(q), ChW'(vv), ChW'(p)};
            2: res = '{ChW'(p), ChW'(vv), ChW'(t)};
            3: res = '{ChW'(p), ChW'(q), ChW'(vv)};
            4: res = '{ChW'(t), ChW'(p), ChW'(vv)};
            default: res = '{ChW'(vv), ChW'(p), ChW'(q)};
          endcase
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driving and checking
  // ---------------------------------------------------------------------------

  function automatic color_req_t make_item(
    input logic [OpW-1:0] op,
    input logic [ChW-1:0] r1, input logic [ChW-1:0] g1, input logic [ChW-1:0] b1,
    input logic [ChW-1:0] r2, input logic [ChW-1:0] g2, input logic [ChW-1:0] b2,
    input logic [ByteW-1:0] f, input logic [ByteW-1:0] h,
    input logic [ByteW-1:0] s, input logic [ByteW-1:0] v);
    return '{op, r1, g1, b1, r2, g2, b2, f, h, s, v};
  endfunction

  // one item per call; valid stays high across back-to-back items
  task automatic send_color_item(input color_req_t req);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= req.op;
    first_red_i <= req.r1;
    first_green_i <= req.g1;
    first_blue_i <= req.b1;
    second_red_i <= req.r2;
    second_green_i <= req.g2;
    second_blue_i <= req.b2;
    factor_i <= req.factor;
    hue_i <= req.hue;
    saturation_i <= req.sat;
    hsv_level_i <= req.level;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_colors.push_back(predict_color(req));
  endtask

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    color_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_colors.size() == 0) begin
        $error("result with no item pending: %0d %0d %0d",
               out_red_o, out_green_o, out_blue_o);
        mismatch_count++;
      end else begin
        want = expected_colors.pop_front();
        if (out_red_o !== want.red) begin
          $error("out_red: expected %0d, actual %0d", want.red, out_red_o);
          mismatch_count++;
        end
        if (out_green_o !== want.green) begin
          $error("out_green: expected %0d, actual %0d", want.green, out_green_o);
          mismatch_count++;
        end
        if (out_blue_o !== want.blue) begin
          $error("out_blue: expected %0d, actual %0d", want.blue, out_blue_o);
          mismatch_count++;
        end
      end
    end
  end

  // hang detection: cycles with no item moving on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= HangLimit) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_blend();
    send_color_item(make_item(OP_BLEND, 31, 31, 31, 0, 0, 0, 8'd0, 0, 0, 0));
    send_color_item(make_item(OP_BLEND, 31, 31, 31, 0, 5, 17, 8'd255, 0, 0, 0));
    send_color_item(make_item(OP_BLEND, 31, 0, 16, 0, 31, 15, 8'd128, 0, 0, 0));
    send_color_item(make_item(OP_BLEND, 0, 31, 0, 31, 0, 31, 8'd1, 0, 0, 0));
  endtask

  task automatic test_darken_lighten();
    send_color_item(make_item(OP_DARKEN, 31, 0, 15, 0, 0, 0, 8'd0, 0, 0, 0));
    send_color_item(make_item(OP_DARKEN, 31, 30, 1, 0, 0, 0, 8'd200, 0, 0, 0));
    send_color_item(make_item(OP_LIGHT, 1, 0, 31, 0, 0, 0, 8'd31, 0, 0, 0));
    send_color_item(make_item(OP_LIGHT, 0, 5, 16, 0, 0, 0, 8'd255, 0, 0, 0));
  endtask

  task automatic test_brightness();
    send_color_item(make_item(OP_BRIGHT, 0, 10, 31, 0, 0, 0, 8'd127, 0, 0, 0));
    // -128 darkens by the clamped 31
    send_color_item(make_item(OP_BRIGHT, 31, 20, 0, 0, 0, 0, 8'd128, 0, 0, 0));
    send_color_item(make_item(OP_BRIGHT, 31, 1, 0, 0, 0, 0, 8'd255, 0, 0, 0));
    send_color_item(make_item(OP_BRIGHT, 7, 8, 9, 0, 0, 0, 8'd0, 0, 0, 0));
  endtask

  task automatic test_invert_gray();
    send_color_item(make_item(OP_INVERT, 0, 31, 10, 0, 0, 0, 8'd0, 0, 0, 0));
    send_color_item(make_item(OP_GRAY, 31, 31, 31, 0, 0, 0, 8'd0, 0, 0, 0));
    send_color_item(make_item(OP_GRAY, 0, 0, 0, 31, 31, 31, 8'd255, 0, 0, 0));
  endtask

  task automatic test_hsv();
    // zero saturation gives gray whatever the hue
    send_color_item(make_item(OP_HSV, 0, 0, 0, 0, 0, 0, 0, 8'd100, 8'd0, 8'd255));
    // sector edges, hue 215 and up in the last sector
    send_color_item(make_item(OP_HSV, 0, 0, 0, 0, 0, 0, 0, 8'd0, 8'd255, 8'd255));
    send_color_item(make_item(OP_HSV, 0, 0, 0, 0, 0, 0, 0, 8'd42, 8'd255, 8'd255));
    send_color_item(make_item(OP_HSV, 0, 0, 0, 0, 0, 0, 0, 8'd43, 8'd255, 8'd255));
    send_color_item(make_item(OP_HSV, 0, 0, 0, 0, 0, 0, 0, 8'd214, 8'd128, 8'd200));
    send_color_item(make_item(OP_HSV, 0, 0, 0, 0, 0, 0, 0, 8'd215, 8'd255, 8'd255));
    send_color_item(make_item(OP_HSV, 0, 0, 0, 0, 0, 0, 0, 8'd255, 8'd1, 8'd0));
  endtask

  task automatic test_unused_op();
    send_color_item(make_item(OpPassThru, 21, 10, 31, 0, 0, 0, 8'd255, 8'd255, 8'd255,
                              8'd255));
  endtask

  function automatic logic [ByteW-1:0] pick_byte();
    logic [ByteW-1:0] corners[8] = '{8'd0, 8'd1, 8'd31, 8'd32, 8'd127, 8'd128, 8'd129,
                                     8'd255};
    if ($urandom_range(4) == 0) return corners[$urandom_range(7)];
    return ByteW'($urandom_range(255));
  endfunction

  function automatic logic [ChW-1:0] pick_chan();
    if ($urandom_range(5) == 0) return ($urandom_range(1) != 0) ? ChMax : '0;
    return ChW'($urandom_range(31));
  endfunction

  task automatic test_random_stream(input int unsigned n_items, input int unsigned idle_p,
                                    input int unsigned stall_p);
    color_req_t req;
    send_idle_pct = idle_p;
    stall_pct = stall_p;
    repeat (n_items) begin
      req.op = OpW'($urandom_range(7));
      req.r1 = pick_chan();
      req.g1 = pick_chan();
      req.b1 = pick_chan();
      req.r2 = pick_chan();
      req.g2 = pick_chan();
      req.b2 = pick_chan();
      req.factor = pick_byte();
      req.hue = pick_byte();
      req.sat = ($urandom_range(9) == 0) ? 8'd0 : pick_byte();
      req.level = pick_byte();
      send_color_item(req);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_blend();
    test_darken_lighten();
    test_brightness();
    test_invert_gray();
    test_hsv();
    test_unused_op();

    test_random_stream(325, 0, 0);
    test_random_stream(325, 85, 0);
    test_random_stream(325, 0, 85);
    test_random_stream(325, 33, 33);

    // let the pipe empty
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/rgb_cop_pkg.sv
hdl/rgb_cop_decode.sv
hdl/rgb_cop_mult.sv
hdl/rgb_cop_final.sv
hdl/rgb555_color_op_unit_core.sv
bench/tb_rgb555_color_op_unit_core.sv
